// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the I2C master bit engine.
// Depends on a clk and an active-low rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/i2cm_pkg.sv
// Package for the I2C master bit engine: command codes, state and result types.
// No dependencies; imported by i2cm_step and i2c_master_bit_engine_core.
`default_nettype none

package i2cm_pkg;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_WRITE   = 3'd3,
    CMD_READ    = 3'd4,
    CMD_WAITACK = 3'd5,
    CMD_SENDACK = 3'd6
  } cmd_t;

  // register index within the configuration port (paddr[2])
  localparam logic REG_PHASE_TICKS = 1'b0;
  localparam logic REG_ACK_RETRY   = 1'b1;

  localparam logic [7:0] PHASE_TICKS_RST = 8'd4;
  localparam logic [7:0] ACK_RETRY_RST   = 8'd200;
  localparam logic [2:0] LAST_BIT        = 3'd7;

  typedef struct packed {
    cmd_t       cmd;
    logic [1:0] step;
    logic [2:0] bit_idx;
    logic [7:0] delay;
    logic [7:0] retry;
    logic [7:0] shift;
    logic       scl;
    logic       sda;
    logic       ack_fail;
    logic [7:0] rbyte;
  } i2cm_state_t;

  typedef struct packed {
    logic       ack_failed;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_level;
    logic       scl_level;
  } i2cm_res_t;

endpackage

`default_nettype wire

// File: rtl/i2cm_step.sv
// Next-state and result logic for one bus tick of the I2C master bit engine.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_step
  import i2cm_pkg::*;
(
  input  i2cm_state_t cur,
  input  logic [2:0]  op,
  input  logic [7:0]  wdata,
  input  logic        sda_in,
  input  logic [7:0]  phase_ticks,
  input  logic [7:0]  retry_limit,
  output i2cm_state_t nxt,
  output i2cm_res_t   res
);

  logic       op_ok;
  logic [7:0] ticks;
  logic [7:0] dly_dec;
  logic [7:0] retry_inc;
  logic       do_sample;
  logic       done;

  assign op_ok     = (op >= 3'(CMD_START)) && (op <= 3'(CMD_SENDACK));
  assign ticks     = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
  assign dly_dec   = (cur.delay != 8'd0) ? cur.delay - 8'd1 : 8'd0;
  assign retry_inc = cur.retry + 8'd1;

  always_comb begin
    nxt       = cur;
    done      = 1'b0;
    do_sample = 1'b0;
    if (cur.cmd == CMD_NONE) begin
      if (op_ok) begin
        nxt.cmd     = cmd_t'(op);
        nxt.step    = 2'd0;
        nxt.bit_idx = 3'd0;
        nxt.retry   = 8'd0;
        nxt.shift   = (cmd_t'(op) == CMD_WRITE) ? wdata : 8'd0;
        nxt.delay   = ticks;
        unique case (cmd_t'(op))
          CMD_START: begin
            nxt.scl = 1'b1; nxt.sda = 1'b1;
          end
          CMD_STOP: begin
            nxt.scl = 1'b0; nxt.sda = 1'b0;
          end
          CMD_WRITE: begin
            nxt.scl = 1'b0; nxt.sda = wdata[7];
          end
          CMD_READ, CMD_WAITACK: begin
            nxt.scl = 1'b1; nxt.sda = 1'b1;
          end
          default: begin
            // send ack: pull SCL low, keep SDA where it was
            nxt.scl = 1'b0;
          end
        endcase
      end
    end else if (cur.cmd == CMD_WAITACK && cur.step == 2'd1) begin
      do_sample = 1'b1;
    end else begin
      nxt.delay = dly_dec;
      if (dly_dec == 8'd0) begin
        unique case (cur.cmd)
          CMD_START: begin
            if (cur.step == 2'd0) begin
              nxt.step = 2'd1; nxt.scl = 1'b1; nxt.sda = 1'b0; nxt.delay = ticks;
            end else begin
              nxt.cmd = CMD_NONE; nxt.step = 2'd0; done = 1'b1;
              nxt.scl = 1'b0; nxt.sda = 1'b0;
            end
          end
          CMD_STOP: begin
            if (cur.step == 2'd0) begin
              nxt.step = 2'd1; nxt.scl = 1'b1; nxt.sda = 1'b0; nxt.delay = ticks;
            end else begin
              nxt.cmd = CMD_NONE; nxt.step = 2'd0; done = 1'b1;
              nxt.scl = 1'b1; nxt.sda = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (cur.step == 2'd0) begin
              nxt.step = 2'd1; nxt.scl = 1'b1; nxt.sda = cur.shift[7]; nxt.delay = ticks;
            end else if (cur.bit_idx == LAST_BIT) begin
              nxt.cmd = CMD_NONE; nxt.step = 2'd0; done = 1'b1;
              nxt.scl = 1'b0;
            end else begin
              nxt.bit_idx = cur.bit_idx + 3'd1;
              nxt.shift   = {cur.shift[6:0], 1'b0};
              nxt.step    = 2'd0;
              nxt.scl     = 1'b0;
              nxt.sda     = cur.shift[6];
              nxt.delay   = ticks;
            end
          end
          CMD_READ: begin
            if (cur.step == 2'd0) begin
              nxt.shift = {cur.shift[6:0], sda_in};
              nxt.step  = 2'd1; nxt.scl = 1'b0; nxt.sda = 1'b1; nxt.delay = ticks;
            end else if (cur.bit_idx == LAST_BIT) begin
              nxt.rbyte = cur.shift;
              nxt.cmd = CMD_NONE; nxt.step = 2'd0; done = 1'b1;
              nxt.scl = 1'b0; nxt.sda = 1'b1;
            end else begin
              nxt.bit_idx = cur.bit_idx + 3'd1;
              nxt.step = 2'd0; nxt.scl = 1'b1; nxt.sda = 1'b1; nxt.delay = ticks;
            end
          end
          CMD_WAITACK: begin
            nxt.step  = 2'd1;
            do_sample = 1'b1;
          end
          default: begin
            // send ack
            if (cur.step == 2'd0) begin
              nxt.step = 2'd1; nxt.scl = 1'b0; nxt.sda = 1'b0; nxt.delay = ticks;
            end else if (cur.step == 2'd1) begin
              nxt.step = 2'd2; nxt.scl = 1'b1; nxt.sda = 1'b0; nxt.delay = ticks;
            end else begin
              nxt.cmd = CMD_NONE; nxt.step = 2'd0; done = 1'b1;
              nxt.scl = 1'b0; nxt.sda = 1'b0;
            end
          end
        endcase
      end
    end

    // acknowledge sample: low ends it, high counts toward the retry limit
    if (do_sample) begin
      if (!sda_in) begin
        nxt.ack_fail = 1'b0;
        nxt.cmd = CMD_NONE; nxt.step = 2'd0; nxt.delay = 8'd0; done = 1'b1;
        nxt.scl = 1'b0; nxt.sda = 1'b0;
      end else begin
        nxt.retry = retry_inc;
        if (retry_inc >= retry_limit) begin
          nxt.ack_fail = 1'b1;
          nxt.cmd = CMD_NONE; nxt.step = 2'd0; nxt.delay = 8'd0; done = 1'b1;
          nxt.scl = 1'b0; nxt.sda = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res.scl_level  = nxt.scl;
    res.sda_level  = nxt.sda;
    res.busy_res   = (nxt.cmd != CMD_NONE);
    res.done_res   = done;
    res.read_data  = nxt.rbyte;
    res.ack_failed = nxt.ack_fail;
  end

endmodule

`default_nettype wire

// File: rtl/i2c_master_bit_engine_core.sv
// Top level of the I2C master bit engine: tick stream in, line levels out.
// Depends on i2cm_pkg, i2cm_step and assert_macros.svh.
//
//  channel | direction | transfer carries
//  --------+-----------+-------------------------------------------------
//  in_     | slave     | one bus tick: operation, write_data, sda_sample
//  out_    | master    | one result per tick: levels, busy, done, data, ack
//  cfg_    | APB       | phase_ticks at 0x0, ack_retry_limit at 0x4
//
// The engine state registers update on the cycle each tick is accepted,
// and the result lands in the output register.
// One tick per cycle is sustained while out_tready is high.
// Reset (rst_n low, synchronous) idles the engine with both lines released.
// When the output stalls, one more result parks in a skid register; in_tready
// drops only while that skid register is full.
`default_nettype none

module i2c_master_bit_engine_core
  import i2cm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // [2:0] operation, [10:3] write_data, [11] sda_sample, [15:12] zero
  input  wire logic [15:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res,
  // [11:4] read_data, [12] ack_failed, [15:13] zero
  output logic [15:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

`include "assert_macros.svh"

  // configuration registers
  logic [7:0] phase_ticks_r;
  logic [7:0] ack_retry_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
      ack_retry_r   <= ACK_RETRY_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_PHASE_TICKS: phase_ticks_r <= cfg_pwdata[7:0];
        REG_ACK_RETRY:   ack_retry_r   <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_PHASE_TICKS: cfg_prdata = {24'd0, phase_ticks_r};
      REG_ACK_RETRY:   cfg_prdata = {24'd0, ack_retry_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // engine state
  i2cm_state_t state_r;
  i2cm_state_t state_nxt;
  i2cm_res_t   res_nxt;
  logic        in_fire;

  assign in_fire = in_tvalid && in_tready;

  i2cm_step u_step (
    .cur         (state_r),
    .op          (in_tdata[2:0]),
    .wdata       (in_tdata[10:3]),
    .sda_in      (in_tdata[11]),
    .phase_ticks (phase_ticks_r),
    .retry_limit (ack_retry_r),
    .nxt         (state_nxt),
    .res         (res_nxt)
  );

  // advance the engine one tick per accepted transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{cmd: CMD_NONE, step: 2'd0, bit_idx: 3'd0, delay: 8'd0,
                   retry: 8'd0, shift: 8'd0, scl: 1'b1, sda: 1'b1,
                   ack_fail: 1'b0, rbyte: 8'd0};
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // output register plus one skid entry
  logic      out_valid_r;
  logic      skid_valid_r;
  i2cm_res_t out_data_r;
  i2cm_res_t skid_data_r;
  logic      out_take;

  assign out_take  = out_valid_r && out_tready;
  assign in_tready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      // output stage frees up: drain skid first, else take the new tick
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_fire) begin
        out_data_r <= res_nxt;
      end
    end else if (in_fire) begin
      skid_data_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_data_r};

  // skid only ever holds a result behind a full output register
  `ASSERT_CLK(a_skid_behind_out, skid_valid_r |-> out_valid_r, "skid full with output empty")

  // a finished command is never reported busy in the same result
  `ASSERT_NEVER(a_done_not_busy, out_valid_r && out_data_r.done_res && out_data_r.busy_res,
    "done and busy in one result")

  // an idle engine holds no pending phase delay
  `ASSERT_CLK(a_idle_no_delay, (state_r.cmd == CMD_NONE) |-> (state_r.delay == 8'd0),
    "idle engine with delay pending")

  // skid fills only while the output is stalled
  `ASSERT_CLK(a_skid_on_stall, $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready),
    "skid loaded without a stall")

endmodule

`default_nettype wire
